FILE: hdl/hbfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbfa_pkg
// Types and constants for the harmonic bond force accumulator.
// ----------------------------------------------------------------------------
package hbfa_pkg;

  localparam int CFG_W  = 31;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 32;
  localparam int ACC_W  = 48;
  localparam int STAT_W = 2;

  localparam logic [2:0] REG_BOX_X     = 3'd0;
  localparam logic [2:0] REG_BOX_Y     = 3'd1;
  localparam logic [2:0] REG_BOX_Z     = 3'd2;
  localparam logic [2:0] REG_STIFFNESS = 3'd3;
  localparam logic [2:0] REG_REST      = 3'd4;

  localparam logic OP_BOND = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SELF = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [ACC_W-1:0] force_x;
    logic signed [ACC_W-1:0] force_y;
    logic signed [ACC_W-1:0] force_z;
  } result_t;

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                      logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s > $signed({1'b0, ACC_MAX})) return ACC_MAX;
    if (s < $signed({1'b1, ACC_MIN})) return ACC_MIN;
    return s[ACC_W-1:0];
  endfunction

endpackage

FILE: hdl/harmonic_bond_force_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_bond_force_accumulator_unit
// Harmonic bond force with minimum-image wrap, accumulated per particle.
// ----------------------------------------------------------------------------
// Drive start with a command in cmd while busy is low; the command transfers
// at that edge. Opcode bond wraps the displacement, takes r by a bit-serial
// square root (32 steps) and r0/r by a restoring divider (48 steps), scales
// the factor and the three components with 24-bit partial products, and
// then does a read-modify-write of particle b and then particle a in the
// force memory (one synchronous read port). Opcode read returns and clears
// one entry. A self bond ends without touching the memory, and a bond whose
// root is zero ends after the square root; both return only a status code.
// done is high for a single cycle, with the result on res; the receiver
// cannot stall it. busy stays high from the transfer until the done cycle,
// in which the next command can transfer. After rst the unit sweeps the
// memory to zero, one entry per cycle, with busy high; register writes on
// cfg_we are taken at any time and the registers return to their reset
// values.
// ----------------------------------------------------------------------------
module harmonic_bond_force_accumulator_unit
  import hbfa_pkg::*;
#(
  parameter int PARTICLE_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output result_t          res,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRAP, S_SQ, S_SQRT, S_DIV, S_FAC, S_MUL,
    S_RD, S_UPD, S_DONE
  } state_t;

  state_t state;
  logic [CFG_W-1:0] box_x, box_y, box_z, stiff, rest;
  cmd_t c;
  logic signed [POS_W-1:0] dx, dy, dz;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [6:0]  cnt;
  logic [47:0] dv_rem, dv_q, dv_num;
  logic [31:0] r;
  logic        mneg;
  logic [55:0] lo_x, lo_y, lo_z;
  logic signed [ACC_W-1:0] fx, fy, fz;
  logic [1:0]  axis;
  logic        side;
  logic [AW:0] clr;
  logic        in_rng;
  logic [AW-1:0] addr;

  logic [3*ACC_W-1:0] mem [PARTICLE_COUNT];
  logic [3*ACC_W-1:0] rd_word;
  logic signed [ACC_W-1:0] rd_x, rd_y, rd_z;
  logic        we;
  logic [AW-1:0] wa;
  logic signed [ACC_W-1:0] wd_x, wd_y, wd_z;

  always_ff @(posedge clk) begin
    rd_word <= mem[addr];
    if (we) begin
      mem[wa] <= {wd_x, wd_y, wd_z};
    end
  end

  assign rd_x = rd_word[3*ACC_W-1:2*ACC_W];
  assign rd_y = rd_word[2*ACC_W-1:ACC_W];
  assign rd_z = rd_word[ACC_W-1:0];

  function automatic logic signed [POS_W-1:0] wrap(logic signed [POS_W-1:0] pb,
                                                   logic signed [POS_W-1:0] pa,
                                                   logic [CFG_W-1:0] len);
    logic signed [POS_W+2:0] d, l;
    d = {{3{pb[POS_W-1]}}, pb} - {{3{pa[POS_W-1]}}, pa};
    l = {4'b0, len};
    if ((d <<< 1) >= l) d = d - l;
    else if ((d <<< 1) < -l) d = d + l;
    if (d > 35'sh7FFFFFFF) d = 35'sh7FFFFFFF;
    if (d < -35'sh80000000) d = -35'sh80000000;
    return d[POS_W-1:0];
  endfunction

  function automatic logic [31:0] absv(logic signed [POS_W-1:0] v);
    return v[POS_W-1] ? 32'(-{1'b0, v}) : v;
  endfunction

  // add the high half of |m| * K to the low half, shift, cap
  function automatic logic [63:0] fac_cap(logic [63:0] lo, logic [23:0] mh,
                                          logic [CFG_W-1:0] k);
    logic [79:0] p;
    p = 80'(lo) + {56'(mh * k), 24'b0};
    p = p >> 15;
    return (p > 80'(ACC_MAX)) ? 64'(ACC_MAX) : p[63:0];
  endfunction

  function automatic logic [55:0] comp_lo(logic [47:0] f,
                                          logic signed [POS_W-1:0] d);
    return 56'(f[23:0] * absv(d));
  endfunction

  function automatic logic signed [ACC_W-1:0] comp_hi(logic [47:0] f,
                                                      logic [55:0] lo, logic fn,
                                                      logic signed [POS_W-1:0] d);
    logic [79:0] p;
    logic [63:0] q;
    p = {24'b0, lo} + {56'(f[47:24] * absv(d)), 24'b0};
    q = p[79:16];
    if (q > 64'(ACC_MAX)) q = 64'(ACC_MAX);
    return (fn ^ d[POS_W-1]) ? -$signed(q[ACC_W-1:0]) : $signed(q[ACC_W-1:0]);
  endfunction

  logic [63:0] sq_try;
  logic [48:0] dv_try;
  assign sq_try = sq_res + sq_bit;
  assign dv_try = {dv_rem, dv_num[47]} - {17'b0, r};

  logic [AW-1:0] idx_a, idx_b;
  assign idx_a = AW'(c.index_a);
  assign idx_b = AW'(c.index_b);
  logic ok_a, ok_b;
  assign ok_a = 32'(c.index_a) < PARTICLE_COUNT;
  assign ok_b = 32'(c.index_b) < PARTICLE_COUNT;

  always_comb begin
    addr = side ? idx_a : idx_b;
    in_rng = side ? ok_a : ok_b;
    we = 1'b0;
    wa = addr;
    wd_x = '0; wd_y = '0; wd_z = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr[AW-1:0];
    end else if (state == S_UPD && in_rng) begin
      we = 1'b1;
      if (c.opcode == OP_BOND) begin
        wd_x = sat_add(rd_x, side ? -fx : fx);
        wd_y = sat_add(rd_y, side ? -fy : fy);
        wd_z = sat_add(rd_z, side ? -fz : fz);
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      box_x <= 31'd1048576; box_y <= 31'd1048576; box_z <= 31'd1048576;
      stiff <= 31'd65536;   rest  <= 31'd65536;
      side  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BOX_X:     box_x <= cfg_data;
          REG_BOX_Y:     box_y <= cfg_data;
          REG_BOX_Z:     box_z <= cfg_data;
          REG_STIFFNESS: stiff <= cfg_data;
          REG_REST:      rest  <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == PARTICLE_COUNT - 1) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          c <= cmd;
          fx <= '0; fy <= '0; fz <= '0;
          if (cmd.opcode == OP_READ) begin
            side <= 1'b1;
            state <= S_RD;
          end else if (cmd.index_a == cmd.index_b) begin
            res <= '{ST_SELF, '0, '0, '0};
            state <= S_DONE;
          end else begin
            side <= 1'b0;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          dx <= wrap(c.pos_b_x, c.pos_a_x, box_x);
          dy <= wrap(c.pos_b_y, c.pos_a_y, box_y);
          dz <= wrap(c.pos_b_z, c.pos_a_z, box_z);
          axis <= 2'd0;
          sq_v <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          sq_v <= sq_v +
                  ((axis == 2'd0) ? 64'(absv(dx) * absv(dx)) :
                   (axis == 2'd1) ? 64'(absv(dy) * absv(dy)) :
                                    64'(absv(dz) * absv(dz)));
          axis <= axis + 1'b1;
          if (axis == 2'd2) begin
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            cnt <= 7'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 7'd31) state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 7'd32) begin
            r <= sq_res[31:0];
            if (sq_res[31:0] == 32'd0) begin
              res <= '{ST_ZERO, '0, '0, '0};
              state <= S_DONE;
            end
            dv_rem <= '0; dv_q <= '0;
            dv_num <= {1'b0, rest, 16'b0};
            cnt <= 7'd33;
          end else begin
            if (!dv_try[48]) begin
              dv_rem <= dv_try[47:0];
              dv_q <= {dv_q[46:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[46:0], dv_num[47]};
              dv_q <= {dv_q[46:0], 1'b0};
            end
            dv_num <= {dv_num[46:0], 1'b0};
            cnt <= cnt + 1'b1;
            if (cnt == 7'd80) state <= S_FAC;
          end
        end
        S_FAC: begin
          mneg <= (dv_q < 48'd65536);
          sq_v <= (dv_q < 48'd65536) ? 64'(48'd65536 - dv_q) : 64'(dv_q - 48'd65536);
          state <= S_MUL;
          axis <= 2'd0;
        end
        S_MUL: begin
          case (axis)
            2'd0: begin
              sq_res <= 64'(sq_v[23:0] * stiff);
              axis <= 2'd1;
            end
            2'd1: begin
              sq_res <= fac_cap(sq_res, sq_v[47:24], stiff);
              axis <= 2'd2;
            end
            2'd2: begin
              lo_x <= comp_lo(sq_res[47:0], dx);
              lo_y <= comp_lo(sq_res[47:0], dy);
              lo_z <= comp_lo(sq_res[47:0], dz);
              axis <= 2'd3;
            end
            default: begin
              fx <= comp_hi(sq_res[47:0], lo_x, mneg, dx);
              fy <= comp_hi(sq_res[47:0], lo_y, mneg, dy);
              fz <= comp_hi(sq_res[47:0], lo_z, mneg, dz);
              side <= 1'b0;
              state <= S_RD;
            end
          endcase
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          if (c.opcode == OP_READ) begin
            res <= '{ST_OK, in_rng ? rd_x : '0, in_rng ? rd_y : '0, in_rng ? rd_z : '0};
            state <= S_DONE;
          end else if (!side) begin
            side <= 1'b1;
            state <= S_RD;
          end else begin
            res <= '{ST_OK, fx, fy, fz};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work in flight");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> busy) else $error("transfer not held");
  a_self_status: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_SELF) |-> c.index_a == c.index_b)
    else $error("self status on distinct particles");

endmodule

FILE: tb/tb_harmonic_bond_force_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_harmonic_bond_force_accumulator_unit
// Self-checking bench for the harmonic bond force accumulator.
// ----------------------------------------------------------------------------
// Bond and read commands go in through the start/busy handshake with random
// gaps. A local model of the wrap, square root, divide, force scaling and
// per-particle saturating accumulators predicts each result. Every done
// strobe is checked field by field against the oldest prediction. Register
// settings are changed only while the unit is idle, and cover the extremes.
// ----------------------------------------------------------------------------
module tb_harmonic_bond_force_accumulator_unit;
  import hbfa_pkg::*;

  localparam int NPART = 1024;
  localparam logic [2:0] REG_SPARE  = 3'd5;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint LIM48 = 64'sh7FFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  result_t res;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  longint box_len[3];
  longint stiff_k, rest_r0;
  longint force_acc[3][NPART];
  result_t pending_forces[$];
  int errors = 0;
  bit no_gaps = 0;

  harmonic_bond_force_accumulator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_harmonic_bond_force_accumulator_unit NOT OK");
    $finish;
  end

  function automatic longint wrap_disp(longint d, longint l);
    if (2 * d >= l) d -= l;
    else if (2 * d < -l) d += l;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d;
  endfunction

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] mul_clip(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = a * b;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint axis_force(bit [63:0] fmag, bit fneg, longint d);
    bit neg;
    bit [63:0] p;
    neg = fneg != (d < 0);
    p = mul_clip(fmag, d < 0 ? -d : d) >> 16;
    if (p > LIM48) p = LIM48;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint sat48(longint v);
    if (v > LIM48) return LIM48;
    if (v < -LIM48 - 1) return -LIM48 - 1;
    return v;
  endfunction

  function automatic result_t bond_force(cmd_t c);
    result_t o;
    longint d[3], f[3], m;
    bit [63:0] s, r, q, mm, fmag;
    bit mneg;
    o = '0;
    if (c.opcode == OP_READ) begin
      o.force_x = ACC_W'(force_acc[0][c.index_a]);
      o.force_y = ACC_W'(force_acc[1][c.index_a]);
      o.force_z = ACC_W'(force_acc[2][c.index_a]);
      for (int k = 0; k < 3; k++) force_acc[k][c.index_a] = 0;
      return o;
    end
    if (c.index_a == c.index_b) begin
      o.status = ST_SELF;
      return o;
    end
    d[0] = wrap_disp(longint'(c.pos_b_x) - longint'(c.pos_a_x), box_len[0]);
    d[1] = wrap_disp(longint'(c.pos_b_y) - longint'(c.pos_a_y), box_len[1]);
    d[2] = wrap_disp(longint'(c.pos_b_z) - longint'(c.pos_a_z), box_len[2]);
    s = 64'(d[0] * d[0]) + 64'(d[1] * d[1]) + 64'(d[2] * d[2]);
    r = root64(s);
    if (r == 0) begin
      o.status = ST_ZERO;
      return o;
    end
    q = (64'(rest_r0) << 16) / r;
    m = longint'(q) - 65536;
    mneg = m < 0;
    mm = mneg ? -m : m;
    fmag = mul_clip(64'(stiff_k), mm) >> 15;
    if (fmag > LIM48) fmag = LIM48;
    for (int k = 0; k < 3; k++) begin
      f[k] = axis_force(fmag, mneg, d[k]);
      force_acc[k][c.index_b] = sat48(force_acc[k][c.index_b] + f[k]);
      force_acc[k][c.index_a] = sat48(force_acc[k][c.index_a] - f[k]);
    end
    o.force_x = ACC_W'(f[0]);
    o.force_y = ACC_W'(f[1]);
    o.force_z = ACC_W'(f[2]);
    return o;
  endfunction

  task automatic report(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (pending_forces.size() == 0) begin
        report("unexpected result", res.force_x, '0);
      end else begin
        exp = pending_forces.pop_front();
        if (res.status !== exp.status)
          report("status", ACC_W'(res.status), ACC_W'(exp.status));
        if (res.force_x !== exp.force_x) report("force_x", res.force_x, exp.force_x);
        if (res.force_y !== exp.force_y) report("force_y", res.force_y, exp.force_y);
        if (res.force_z !== exp.force_z) report("force_z", res.force_z, exp.force_z);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_forces = {pending_forces, bond_force(c)};
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BOX_X: box_len[0] = longint'(val);
      REG_BOX_Y: box_len[1] = longint'(val);
      REG_BOX_Z: box_len[2] = longint'(val);
      REG_STIFFNESS: stiff_k = longint'(val);
      REG_REST: rest_r0 = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_W-1:0] bx, logic [CFG_W-1:0] by,
                          logic [CFG_W-1:0] bz, logic [CFG_W-1:0] k,
                          logic [CFG_W-1:0] r0);
    settle();
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_REST, r0);
  endtask

  function automatic cmd_t make_bond(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                     logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
                                     logic [POS_W-1:0] az, logic [POS_W-1:0] bx,
                                     logic [POS_W-1:0] by, logic [POS_W-1:0] bz);
    cmd_t c;
    c = {OP_BOND, a, b, ax, ay, az, bx, by, bz};
    return c;
  endfunction

  function automatic cmd_t make_read(logic [IDX_W-1:0] a);
    cmd_t c;
    c = {OP_READ, a, IDX_W'($urandom), 32'($urandom), 32'($urandom),
         32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
    return c;
  endfunction

  task automatic test_directed();
    send(make_read(10'd0));
    send(make_bond(10'd1, 10'd2, 0, 0, 0, 32'h0002_0000, 0, 0));
    send(make_bond(10'd2, 10'd1, 0, 0, 0, 0, 32'h0000_8000, 0));
    send(make_bond(10'd3, 10'd3, 1, 2, 3, 4, 5, 6));
    send(make_bond(10'd4, 10'd5, 7, 7, 7, 7, 7, 7));
    send(make_bond(10'd1023, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(make_bond(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(make_bond(10'd6, 10'd7, 0, 0, 0, 32'h0008_0000, 32'hFFF8_0000, 0));
    send(make_bond(10'd6, 10'd7, 0, 0, 0, 32'h0007_FFFF, 32'hFFF8_0001, 1));
    send(make_bond(10'd8, 10'd9, 0, 0, 0, 32'h0010_0000, 0, 0));
    send(make_bond(10'd8, 10'd9, 0, 0, 0, 1, 0, 0));
    for (int i = 0; i < 10; i++) send(make_read(IDX_W'(i)));
    send(make_read(10'd1023));
    // unused register index must be dropped
    settle();
    write_reg(REG_UNUSED, '1);
    write_reg(REG_SPARE, '1);
    send(make_bond(10'd11, 10'd12, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0));
    send(make_read(10'd12));
    // zero box length disables wrapping
    set_regs('0, '0, '0, 31'h0001_0000, 31'h0001_0000);
    send(make_bond(10'd13, 10'd14, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send(make_bond(10'd13, 10'd14, 0, 32'h4000_0000, 0, 0, 32'hC000_0000, 0));
    send(make_read(10'd13));
  endtask

  task automatic random_phase(int count, int pool);
    cmd_t c;
    int kind;
    logic [IDX_W-1:0] a, b;
    logic [POS_W-1:0] p[6];
    for (int i = 0; i < count; i++) begin
      no_gaps = (i % 100) < 20;
      kind = $urandom_range(0, 99);
      a = (pool != 0) ? IDX_W'($urandom_range(0, pool - 1)) : IDX_W'($urandom);
      b = (pool != 0) ? IDX_W'($urandom_range(0, pool - 1)) : IDX_W'($urandom);
      for (int k = 0; k < 6; k++) p[k] = $urandom;
      if (kind < 20) begin
        c = make_read(a);
      end else if (kind < 75) begin
        for (int k = 0; k < 3; k++)
          p[k + 3] = p[k] + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        c = make_bond(a, b, p[0], p[1], p[2], p[3], p[4], p[5]);
      end else if (kind < 80) begin
        c = make_bond(a, a, p[0], p[1], p[2], p[3], p[4], p[5]);
      end else if (kind < 83) begin
        c = make_bond(a, b, p[0], p[1], p[2], p[0], p[1], p[2]);
      end else begin
        c = make_bond(a, b, p[0], p[1], p[2], p[3], p[4], p[5]);
      end
      send(c);
    end
    no_gaps = 0;
  endtask

  task automatic test_random();
    set_regs(31'h0010_0000, 31'h0010_0000, 31'h0010_0000, 31'h0001_0000, 31'h0001_0000);
    random_phase(260, 16);
    set_regs(31'd1, 31'd1, 31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_phase(200, 4);
    set_regs('1, '1, '1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_phase(260, 0);
    set_regs(31'h0004_0000, 31'h0020_0000, 31'h0001_8000, 31'h0000_0001, 31'h0000_0000);
    random_phase(200, 32);
    set_regs(31'h2000_0000, 31'h0100_0000, 31'h7FFF_FFFF, 31'h0400_0000, 31'h0002_8000);
    random_phase(340, 8);
  endtask

  initial begin
    box_len = '{64'd1048576, 64'd1048576, 64'd1048576};
    stiff_k = 65536;
    rest_r0 = 65536;
    foreach (force_acc[k, i]) force_acc[k][i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    settle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_harmonic_bond_force_accumulator_unit OK");
    end else begin
      $display("tb_harmonic_bond_force_accumulator_unit NOT OK");
    end
    $finish;
  end

endmodule
